[rtl/gbps_pkg.sv]
// Shared constants and types of the glyph bit-plane pixel store.
`timescale 1ns / 1ps

package gbps_pkg;

    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;
    localparam int MAX_PLANES_DEF = 8;

    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int PIX_W    = 8;
    localparam int IDX_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam int BPP_W    = 4;
    localparam int DIM_W    = 6;
    localparam int COLB_W   = 4;
    localparam int PSIZE_W  = 10;
    localparam int OFFS_W   = 10;
    localparam int TOTAL_W  = 14;
    localparam int ACC_MIN_W = 13;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BPP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [OP_W-1:0] OP_READ_PIX  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_PIX = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_BYTE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_BYTE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd2;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [BYTE_W-1:0] wdata;
    } mem_ctl_t;

endpackage

[rtl/gbps_if.sv]
// Handshake interfaces for the request, response and configuration channels.
`timescale 1ns / 1ps

interface gbps_req_if;
    import gbps_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  x_pos;
    logic [POS_W-1:0]  y_pos;
    logic [PIX_W-1:0]  pixel_value;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] byte_data;
    modport source (output valid, op, x_pos, y_pos, pixel_value, byte_index, byte_data,
                    input ready);
    modport sink (input valid, op, x_pos, y_pos, pixel_value, byte_index, byte_data,
                  output ready);
endinterface

interface gbps_rsp_if;
    import gbps_pkg::*;
    logic                valid;
    logic                ready;
    logic [PIX_W-1:0]    pixel_out;
    logic [BYTE_W-1:0]   byte_out;
    logic [STATUS_W-1:0] status;
    modport source (output valid, pixel_out, byte_out, status, input ready);
    modport sink (input valid, pixel_out, byte_out, status, output ready);
endinterface

interface gbps_cfg_if;
    import gbps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/gbps_store.sv]
// Byte store of the bit planes with a single address port for writes and registered reads.
`timescale 1ns / 1ps

module gbps_store
    import gbps_pkg::*;
#(
    parameter longint DEPTH = 1024,
    parameter int     AW    = 10
) (
    input  logic              clk,
    input  mem_ctl_t          ctl,
    input  logic [AW-1:0]     addr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= ctl.wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/gbps_ctrl.sv]
// Sequencer and shared address unit that walk the planes for each pixel transaction.
`timescale 1ns / 1ps

module gbps_ctrl
    import gbps_pkg::*;
#(
    parameter int     MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int     MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int     MAX_PLANES  = MAX_PLANES_DEF,
    parameter longint STORE_BYTES = 1024,
    parameter int     AW          = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    gbps_req_if.sink          req,
    gbps_rsp_if.source        rsp,
    gbps_cfg_if.sink          cfg,
    output mem_ctl_t          mem_ctl,
    output logic [AW-1:0]     mem_addr,
    input  logic [BYTE_W-1:0] mem_rdata
);

    localparam int ACC_W = (AW > ACC_MIN_W) ? AW : ACC_MIN_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_MOD   = 3'd5;
    localparam logic [2:0] S_BYTE  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;

    logic [BPP_W-1:0] bpp_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    logic [OP_W-1:0]   op_reg;
    logic [POS_W-1:0]  x_reg;
    logic [POS_W-1:0]  y_reg;
    logic [PIX_W-1:0]  val_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] data_reg;

    logic [PSIZE_W-1:0] psize_reg;
    logic [OFFS_W-1:0]  offs_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [BPP_W-1:0]   plane_reg;
    logic [AW-1:0]      clr_reg;

    logic [PIX_W-1:0]    pix_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                rsp_valid_reg;
    logic [PIX_W-1:0]    rsp_pix_reg;
    logic [BYTE_W-1:0]   rsp_byte_reg;
    logic [STATUS_W-1:0] rsp_status_reg;

    logic [BPP_W-1:0]   planes_c;
    logic [DIM_W-1:0]   width_c;
    logic [DIM_W-1:0]   height_c;
    logic [6:0]         height_sum;
    logic [COLB_W-1:0]  col_bytes;
    logic [TOTAL_W-1:0] total;
    logic [BYTE_W-1:0]  mask;
    logic               pos_bad;
    logic               idx_bad;
    logic               plane_done;
    logic               is_pix_op;
    logic               set_bit;

    always_comb
    begin
        if (bpp_reg == '0)
            planes_c = BPP_W'(1);
        else if (int'(bpp_reg) > MAX_PLANES)
            planes_c = BPP_W'(MAX_PLANES);
        else
            planes_c = bpp_reg;
        if (width_reg == '0)
            width_c = DIM_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            width_c = DIM_W'(MAX_WIDTH);
        else
            width_c = width_reg;
        if (height_reg == '0)
            height_c = DIM_W'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            height_c = DIM_W'(MAX_HEIGHT);
        else
            height_c = height_reg;
    end

    assign height_sum = {1'b0, height_c} + 7'd7;
    assign col_bytes  = height_sum[6:3];
    assign total      = TOTAL_W'(psize_reg) * TOTAL_W'(planes_c);
    assign mask       = 8'h80 >> y_reg[2:0];
    assign is_pix_op  = (op_reg == OP_READ_PIX) || (op_reg == OP_WRITE_PIX);
    assign pos_bad    = ({1'b0, x_reg} >= width_c) || ({1'b0, y_reg} >= height_c);
    assign idx_bad    = ({4'b0, idx_reg} >= total) || (longint'(idx_reg) >= STORE_BYTES);
    assign plane_done = (plane_reg == planes_c) || (longint'(acc_reg) >= STORE_BYTES);
    assign set_bit    = (int'(plane_reg) < 8) && val_reg[plane_reg[2:0]];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (longint'(clr_reg) == STORE_BYTES - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (is_pix_op)
                    state_next = pos_bad ? S_OUT : S_RD;
                else if (idx_bad || (op_reg == OP_LOAD_BYTE))
                    state_next = S_OUT;
                else
                    state_next = S_BYTE;
            end
            S_RD:
            begin
                state_next = plane_done ? S_OUT : S_MOD;
            end
            S_MOD:
            begin
                state_next = S_RD;
            end
            S_BYTE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_ctl  = '0;
        mem_addr = acc_reg[AW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.we = 1'b1;
                mem_addr   = clr_reg;
            end
            S_CHECK:
            begin
                mem_addr      = AW'(idx_reg);
                mem_ctl.wdata = data_reg;
                if (!is_pix_op && !idx_bad)
                begin
                    mem_ctl.we = (op_reg == OP_LOAD_BYTE);
                    mem_ctl.re = (op_reg == OP_READ_BYTE);
                end
            end
            S_RD:
            begin
                mem_ctl.re = !plane_done;
            end
            S_MOD:
            begin
                mem_ctl.we    = (op_reg == OP_WRITE_PIX);
                mem_ctl.wdata = (mem_rdata & ~mask) | (set_bit ? mask : 8'h00);
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            bpp_reg       <= BPP_W'(1);
            width_reg     <= DIM_W'(8);
            height_reg    <= DIM_W'(8);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_BPP:    bpp_reg    <= cfg.data[BPP_W-1:0];
                    REG_WIDTH:  width_reg  <= cfg.data[DIM_W-1:0];
                    REG_HEIGHT: height_reg <= cfg.data[DIM_W-1:0];
                    default:    bpp_reg    <= bpp_reg;
                endcase
            end
            if ((state_reg == S_OUT) && (!rsp_valid_reg || rsp.ready))
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg     <= req.op;
                x_reg      <= req.x_pos;
                y_reg      <= req.y_pos;
                val_reg    <= req.pixel_value;
                idx_reg    <= req.byte_index;
                data_reg   <= req.byte_data;
                pix_reg    <= '0;
                byte_reg   <= '0;
                status_reg <= ST_OK;
            end
            S_SETUP:
            begin
                psize_reg <= PSIZE_W'(col_bytes) * PSIZE_W'(width_c);
                offs_reg  <= OFFS_W'(x_reg) * OFFS_W'(col_bytes)
                             + OFFS_W'(y_reg[POS_W-1:3]);
            end
            S_CHECK:
            begin
                acc_reg   <= ACC_W'(offs_reg);
                plane_reg <= '0;
                if (is_pix_op && pos_bad)
                    status_reg <= ST_BAD_POS;
                else if (!is_pix_op && idx_bad)
                    status_reg <= ST_BAD_IDX;
            end
            S_MOD:
            begin
                if ((op_reg == OP_READ_PIX) && (int'(plane_reg) < 8) && ((mem_rdata & mask) != '0))
                    pix_reg[plane_reg[2:0]] <= 1'b1;
                acc_reg   <= acc_reg + ACC_W'(psize_reg);
                plane_reg <= plane_reg + BPP_W'(1);
            end
            S_BYTE:
            begin
                byte_reg <= mem_rdata;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_pix_reg    <= pix_reg;
                    rsp_byte_reg   <= byte_reg;
                    rsp_status_reg <= status_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.pixel_out = rsp_pix_reg;
    assign rsp.byte_out  = rsp_byte_reg;
    assign rsp.status    = rsp_status_reg;

endmodule

[rtl/glyph_bitplane_pixel_store.sv]
// Top level of the glyph bit-plane pixel store.
//
// The req channel takes one transaction at a time: read pixel, write pixel,
// load raw byte or read raw byte. Each transaction gives exactly one
// transaction on the rsp channel with pixel_out, byte_out and status.
// The cfg channel writes bits_per_pixel, glyph_width and glyph_height; it is
// always ready; the user must see that it is written only while the block is
// idle, since the block itself does not enforce this.
// A pixel transaction walks the planes one by one through a shared address
// adder and the single store port, with a read step and a modify step per
// plane; the modify step writes the byte back for a pixel write.
// A byte transaction, or a pixel transaction whose position is out of range,
// goes from the check state to the output state, a byte read passing through
// its byte step first. req.ready is low while a transaction is in progress.
// After reset the sequencer clears the store one byte per cycle, over every
// byte of the store (1024 with the default sizes); req is not ready during
// that pass. A response waits in its output register while rsp.ready is low;
// the block then holds back only the next response, not the next request.
`timescale 1ns / 1ps

module glyph_bitplane_pixel_store
    import gbps_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gbps_req_if.sink   req,
    gbps_rsp_if.source rsp,
    gbps_cfg_if.sink   cfg
);

    localparam longint STORE_BYTES =
        longint'((MAX_HEIGHT + 7) / 8) * longint'(MAX_WIDTH) * longint'(MAX_PLANES);
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_rdata;

    gbps_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_PLANES  (MAX_PLANES),
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_rdata (mem_rdata)
    );

    gbps_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .rdata (mem_rdata)
    );

endmodule

[rtl/gbps_checker.sv]
// Port-level assertions for the glyph bit-plane pixel store and their bind.
`timescale 1ns / 1ps

module gbps_checker
    import gbps_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [PIX_W-1:0]    pixel_out,
    input logic [BYTE_W-1:0]   byte_out,
    input logic [STATUS_W-1:0] status
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request channel stayed ready after a transaction");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == ST_OK) || (status == ST_BAD_POS) || (status == ST_BAD_IDX))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (pixel_out == '0) && (byte_out == '0))
        else $error("error response carries data");

endmodule

bind glyph_bitplane_pixel_store gbps_checker u_gbps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .pixel_out (rsp.pixel_out),
    .byte_out  (rsp.byte_out),
    .status    (rsp.status)
);
